FILE: src/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DISABLED = 3'd1;
    localparam logic [2:0] ST_NOFIT    = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] request_size;
        logic [31:0] block_offset;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] granted_offset;
    } rsp_t;

endpackage
`default_nettype wire

FILE: src/ffha_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] addr,
    input  wire [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

FILE: src/first_fit_heap_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator over 16-byte granules with coalescing on free.
//
// Channels: s_ request words (action, size, offset), m_ response words
// (status, granted offset), cfg_ write of heap_enabled, taken any cycle out
// of reset. All valid/ready. One request is processed at a time. Headers
// live in one RAM, one entry per granule.
// A disabled, oversize or bad-offset request is answered in the cycle after
// it is taken. Alloc reads each header in turn up to the fitting one and
// writes one more when the block is split. Free checks the header, reads
// the following headers to merge, writes the header back, walks from the
// start up to the freed block, and merges with the block before it if free.
// The next request is taken the cycle after the response word is accepted.
// Reset starts a clearing pass that writes every header entry; no request
// is taken until it ends.
// The response sits in an output register; while the receiver stalls the
// unit holds it and takes no new request.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
    parameter int HEAP_GRANULES = 4096
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_valid,
    output logic            s_ready,
    input  ffha_pkg::req_t  s_data,
    output logic            m_valid,
    input  wire             m_ready,
    output ffha_pkg::rsp_t  m_data,
    input  wire             cfg_valid,
    output logic            cfg_ready,
    input  wire             cfg_data
);

    localparam int AW = $clog2(HEAP_GRANULES);
    localparam int SW = AW + 1;
    localparam int EW = SW + 2;
    localparam logic [SW-1:0] G = SW'(HEAP_GRANULES);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_AREAD, S_AWAIT, S_ASPLIT, S_FREAD, S_FCHK,
        S_NREAD, S_NCHK, S_BREAD, S_BCHK, S_BHDR, S_BWAIT, S_BFIN, S_RESP
    } state_t;

    state_t           state_reg;
    logic             en_reg;
    logic [SW-1:0]    p_reg, h_reg, need_reg, size_reg, hsz_reg;
    ffha_pkg::rsp_t   rsp_reg;
    logic             we;
    logic [AW-1:0]    addr;
    logic [EW-1:0]    wdata, rdata;
    logic             r_valid, r_used;
    logic [SW-1:0]    r_size;
    logic [32:0]      rnd;

    assign r_valid = rdata[EW-1];
    assign r_used  = rdata[EW-2];
    assign r_size  = rdata[SW-1:0];
    assign rnd     = {1'b0, (s_data.request_size == 32'd0) ? 32'd1 : s_data.request_size}
                     + 33'd15;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = aresetn;
    assign m_valid   = (state_reg == S_RESP);
    assign m_data    = rsp_reg;

    ffha_ram #(.WIDTH(EW), .DEPTH(HEAP_GRANULES)) u_hdr (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    always_comb begin
        we    = 1'b0;
        addr  = p_reg[AW-1:0];
        wdata = '0;
        unique case (state_reg)
            S_CLR: begin
                we = 1'b1;
                wdata = (p_reg == '0) ? {1'b1, 1'b0, G - SW'(1)} : '0;
            end
            S_AWAIT: begin
                if (r_valid && !r_used && r_size >= need_reg) begin
                    we = 1'b1;
                    wdata = {1'b1, 1'b1,
                             (r_size >= need_reg + SW'(2)) ? need_reg : r_size};
                end
            end
            S_ASPLIT: begin
                we = 1'b1;
                wdata = {1'b1, 1'b0, size_reg - need_reg - SW'(1)};
            end
            S_NCHK: begin
                if (r_valid && !r_used) begin
                    we = 1'b1;
                    wdata = '0;
                end
            end
            S_BHDR: begin
                we = 1'b1;
                addr = h_reg[AW-1:0];
                wdata = {1'b1, 1'b0, hsz_reg};
            end
            S_BFIN: begin
                we = 1'b1;
                wdata = {1'b1, 1'b0, size_reg + SW'(1) + hsz_reg};
            end
            S_BWAIT: begin
                we = 1'b1;
                addr = h_reg[AW-1:0];
                wdata = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            en_reg    <= 1'b1;
            p_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                en_reg <= cfg_data;
            end
            unique case (state_reg)
                S_CLR: begin
                    p_reg <= p_reg + SW'(1);
                    if (p_reg == G - SW'(1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        if (!en_reg) begin
                            rsp_reg <= '{status: ffha_pkg::ST_DISABLED,
                                         granted_offset: 16'd0};
                            state_reg <= S_RESP;
                        end else if (s_data.action == ffha_pkg::ACT_ALLOC) begin
                            if (s_data.request_size > 32'hFFFF_FFF0) begin
                                rsp_reg <= '{status: ffha_pkg::ST_OVERFLOW,
                                             granted_offset: 16'd0};
                                state_reg <= S_RESP;
                            end else if (rnd[32:4] > 29'(HEAP_GRANULES)) begin
                                rsp_reg <= '{status: ffha_pkg::ST_NOFIT,
                                             granted_offset: 16'd0};
                                state_reg <= S_RESP;
                            end else begin
                                rsp_reg <= '{status: ffha_pkg::ST_OK,
                                             granted_offset: 16'd0};
                                need_reg  <= SW'(rnd[32:4]);
                                p_reg     <= '0;
                                state_reg <= S_AREAD;
                            end
                        end else begin
                            if (s_data.block_offset < 32'd16
                                || s_data.block_offset[31:4] >= 28'(HEAP_GRANULES)
                                || s_data.block_offset[3:0] != 4'd0) begin
                                rsp_reg <= '{status: ffha_pkg::ST_IGNORED,
                                             granted_offset: 16'd0};
                                state_reg <= S_RESP;
                            end else begin
                                rsp_reg <= '{status: ffha_pkg::ST_OK,
                                             granted_offset: 16'd0};
                                h_reg     <= SW'(s_data.block_offset[31:4] - 28'd1);
                                p_reg     <= SW'(s_data.block_offset[31:4] - 28'd1);
                                state_reg <= S_FREAD;
                            end
                        end
                    end
                end
                S_AREAD: state_reg <= S_AWAIT;
                S_AWAIT: begin
                    if (!r_valid) begin
                        rsp_reg.status <= ffha_pkg::ST_NOFIT;
                        state_reg <= S_RESP;
                    end else if (!r_used && r_size >= need_reg) begin
                        rsp_reg.granted_offset <= 16'({p_reg + SW'(1), 4'd0});
                        size_reg <= r_size;
                        if (r_size >= need_reg + SW'(2)) begin
                            p_reg <= p_reg + SW'(1) + need_reg;
                            state_reg <= S_ASPLIT;
                        end else begin
                            state_reg <= S_RESP;
                        end
                    end else if (p_reg + SW'(1) + r_size >= G) begin
                        rsp_reg.status <= ffha_pkg::ST_NOFIT;
                        state_reg <= S_RESP;
                    end else begin
                        p_reg <= p_reg + SW'(1) + r_size;
                        state_reg <= S_AREAD;
                    end
                end
                S_ASPLIT: state_reg <= S_RESP;
                S_FREAD: state_reg <= S_FCHK;
                S_FCHK: begin
                    if (!r_valid || !r_used) begin
                        rsp_reg.status <= ffha_pkg::ST_IGNORED;
                        state_reg <= S_RESP;
                    end else begin
                        hsz_reg <= r_size;
                        p_reg   <= h_reg + SW'(1) + r_size;
                        state_reg <= (h_reg + SW'(1) + r_size >= G) ? S_BHDR : S_NREAD;
                    end
                end
                S_NREAD: state_reg <= S_NCHK;
                S_NCHK: begin
                    if (r_valid && !r_used) begin
                        hsz_reg <= hsz_reg + SW'(1) + r_size;
                        p_reg   <= p_reg + SW'(1) + r_size;
                        state_reg <= (p_reg + SW'(1) + r_size >= G) ? S_BHDR : S_NREAD;
                    end else begin
                        state_reg <= S_BHDR;
                    end
                end
                S_BHDR: begin
                    p_reg <= '0;
                    state_reg <= (h_reg == '0) ? S_RESP : S_BREAD;
                end
                S_BREAD: state_reg <= S_BCHK;
                S_BCHK: begin
                    if (!r_valid) begin
                        state_reg <= S_RESP;
                    end else if (p_reg + SW'(1) + r_size == h_reg) begin
                        size_reg <= r_size;
                        state_reg <= r_used ? S_RESP : S_BFIN;
                    end else if (p_reg + SW'(1) + r_size > h_reg) begin
                        state_reg <= S_RESP;
                    end else begin
                        p_reg <= p_reg + SW'(1) + r_size;
                        state_reg <= S_BREAD;
                    end
                end
                S_BFIN: state_reg <= S_BWAIT;
                S_BWAIT: state_reg <= S_RESP;
                S_RESP: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit heap allocator: a header-level model
// predicts every response word while random alloc/free traffic, bursty input
// and a stalling receiver run through enable settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int NGRAN     = 4096;
    localparam longint CYC_LIMIT = 30000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ffha_pkg::req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ffha_pkg::rsp_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;

    first_fit_heap_allocator_unit #(.HEAP_GRANULES(NGRAN)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // heap model
    bit        hp_valid [NGRAN];
    bit        hp_used  [NGRAN];
    int unsigned hp_size [NGRAN];
    bit        hp_enabled;
    int unsigned live_offsets [$];

    ffha_pkg::req_t pending_reqs [$];
    ffha_pkg::rsp_t expected_rsps [$];
    ffha_pkg::rsp_t pred_rsp;
    int   errors = 0;
    int   n_words = 0;
    int   n_ok = 0;
    longint cycles = 0;
    bit   hold_off = 1'b0;
    bit   drain_hold = 1'b0;
    bit   cfg_req = 1'b0;
    bit   cfg_val = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    function automatic logic [2:0] heap_alloc(input logic [31:0] bytes,
                                              output logic [15:0] off);
        int unsigned p, s, need, nb;
        off = '0;
        p = 0;
        if (bytes == 0) bytes = 1;
        if (bytes > 32'hFFFF_FFF0) return ffha_pkg::ST_OVERFLOW;
        need = (bytes + 15) >> 4;
        while (p < NGRAN) begin
            if (!hp_valid[p]) return ffha_pkg::ST_NOFIT;
            s = hp_size[p];
            if (!hp_used[p] && s >= need) begin
                if (s >= need + 2) begin
                    nb = p + 1 + need;
                    hp_valid[nb] = 1'b1;
                    hp_used[nb] = 1'b0;
                    hp_size[nb] = s - need - 1;
                    hp_size[p] = need;
                end
                hp_used[p] = 1'b1;
                off = 16'((p + 1) * 16);
                return ffha_pkg::ST_OK;
            end
            p = p + 1 + s;
        end
        return ffha_pkg::ST_NOFIT;
    endfunction

    function automatic logic [2:0] heap_free(input logic [31:0] off);
        longint unsigned h, nxt, cur, nn, ns;
        if (off < 16 || longint'(off) >= NGRAN * 16 || off[3:0] != 0)
            return ffha_pkg::ST_IGNORED;
        h = (off >> 4) - 1;
        if (!hp_valid[h] || !hp_used[h]) return ffha_pkg::ST_IGNORED;
        hp_used[h] = 1'b0;
        nxt = h + 1 + hp_size[h];
        while (nxt < NGRAN) begin
            if (!hp_valid[nxt] || hp_used[nxt]) break;
            ns = hp_size[nxt];
            hp_size[h] += 1 + ns;
            hp_valid[nxt] = 1'b0;
            nxt = nxt + 1 + ns;
        end
        cur = 0;
        while (cur < h) begin
            if (!hp_valid[cur]) break;
            nn = cur + 1 + hp_size[cur];
            if (nn == h) begin
                if (!hp_used[cur]) begin
                    hp_size[cur] += 1 + hp_size[h];
                    hp_valid[h] = 1'b0;
                end
                break;
            end
            cur = nn;
        end
        return ffha_pkg::ST_OK;
    endfunction

    function automatic ffha_pkg::rsp_t predict_rsp(input ffha_pkg::req_t r);
        ffha_pkg::rsp_t o;
        logic [15:0] g;
        g = '0;
        if (!hp_enabled) o.status = ffha_pkg::ST_DISABLED;
        else if (r.action == ffha_pkg::ACT_ALLOC) o.status = heap_alloc(r.request_size, g);
        else o.status = heap_free(r.block_offset);
        o.granted_offset = (o.status == ffha_pkg::ST_OK) ? g : 16'd0;
        return o;
    endfunction

    // driver
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                cfg_valid <= 1'b0;
                hp_enabled = cfg_data;
            end else if (cfg_req && !cfg_valid) begin
                cfg_valid <= 1'b1;
                cfg_data <= cfg_val;
                cfg_req = 1'b0;
            end
            if (s_valid && s_ready) begin
                pred_rsp = predict_rsp(s_data);
                expected_rsps.push_back(pred_rsp);
                if (s_data.action == ffha_pkg::ACT_ALLOC && pred_rsp.status == ffha_pkg::ST_OK)
                    live_offsets.push_back(pred_rsp.granted_offset);
                n_words++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) gap_left--;
                if (pending_reqs.size() > 0 && gap_left == 0 && !drain_hold) begin
                    s_valid <= 1'b1;
                    s_data <= pending_reqs.pop_front();
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else
                    s_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    int stall_phase = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("timeout");
            $display("status: fail");
            $finish;
        end
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected word", m_data.status, -1);
                else begin
                    ffha_pkg::rsp_t e;
                    e = expected_rsps.pop_front();
                    if (m_data.status != e.status)
                        report_mismatch("status", m_data.status, e.status);
                    if (m_data.granted_offset != e.granted_offset)
                        report_mismatch("granted_offset", m_data.granted_offset,
                                        e.granted_offset);
                    if (e.status == ffha_pkg::ST_OK) n_ok++;
                end
            end
            stall_phase = (stall_phase + 1) % 23;
            if (hold_off) m_ready <= 1'b0;
            else m_ready <= (stall_phase < 15) || ($urandom_range(0, 1) == 1);
        end
    end

    task automatic push_alloc(input logic [31:0] sz);
        ffha_pkg::req_t r;
        r.action = ffha_pkg::ACT_ALLOC;
        r.request_size = sz;
        r.block_offset = $urandom;
        pending_reqs.push_back(r);
    endtask

    task automatic push_free(input logic [31:0] off);
        ffha_pkg::req_t r;
        r.action = ffha_pkg::ACT_FREE;
        r.request_size = $urandom;
        r.block_offset = off;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drain();
        while (pending_reqs.size() > 0 || s_valid || expected_rsps.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_enable(input bit v);
        cfg_val = v;
        cfg_req = 1'b1;
        @(posedge aclk);
        while (cfg_req || cfg_valid) @(posedge aclk);
    endtask

    task automatic random_traffic(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                case ($urandom_range(0, 3))
                    0: push_alloc($urandom_range(0, 16));
                    1: push_alloc($urandom_range(0, 256));
                    2: push_alloc($urandom_range(0, 2048));
                    default: push_alloc($urandom_range(0, 70000));
                endcase
            end else if (k < 85 && live_offsets.size() > 0) begin
                push_free(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
            end else if (k < 90) begin
                push_free($urandom_range(1, NGRAN) * 16);
            end else if (k < 95) begin
                push_free($urandom);
            end else if (k < 97) begin
                push_alloc($urandom);
            end else begin
                push_alloc(32'hFFFF_FFF0 + $urandom_range(0, 15));
            end
        end
    endtask

    initial begin
        hp_enabled = 1'b1;
        hp_valid[0] = 1'b1;
        hp_size[0] = NGRAN - 1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // directed
        push_alloc(0);
        push_alloc(1);
        push_alloc(16);
        push_alloc(17);
        push_alloc(32'hFFFF_FFF0);
        push_alloc(32'hFFFF_FFF1);
        push_alloc(32'hFFFF_FFFF);
        push_free(0);
        push_free(8);
        push_free(NGRAN * 16);
        push_free(32'hFFFF_FFFF);
        push_free(16);
        push_free(16);
        push_free(48);
        push_free(80);
        push_free(32);
        push_alloc((NGRAN - 1) * 16);
        push_alloc(16);
        push_free(16);
        push_alloc((NGRAN - 1) * 16);
        push_free(16);
        wait_drain();
        write_enable(1'b0);
        push_alloc(16);
        push_free(16);
        push_free(32'h8000_0000);
        wait_drain();
        write_enable(1'b1);
        // fill then long receiver hold-off
        random_traffic(300);
        repeat (50) @(posedge aclk);
        hold_off = 1'b1;
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
        wait_drain();
        write_enable(1'b0);
        random_traffic(60);
        wait_drain();
        write_enable(1'b1);
        random_traffic(400);
        drain_hold = 1'b1;
        while (expected_rsps.size() > 0 || s_valid) @(posedge aclk);
        drain_hold = 1'b0;
        random_traffic(440);
        wait_drain();
        repeat (200) @(posedge aclk);
        $display("covered %0d request words, %0d successful grants or frees", n_words, n_ok);
        $display("enable toggled off and on, overflow, bad frees and full-heap cases hit");
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
